// ----- sv/flas_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flas_pkg
// Shared types and constants for the filament load assist sequencer.
// ----------------------------------------------------------------------------
package flas_pkg;

  localparam int TimeW  = 32;
  localparam int MsW    = 16;
  localparam int StepW  = 6;
  localparam int PhaseW = 3;
  localparam int CfgIdxW = 2;

  // Move phases, encoded as reported on phase_now
  typedef enum logic [PhaseW-1:0] {
    PH_WAIT      = 3'd0,
    PH_PULSE_RET = 3'd1,
    PH_HOLD_RET  = 3'd2,
    PH_PULSE_EXT = 3'd3,
    PH_HOLD_EXT  = 3'd4
  } phase_t;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_RUNOUT_DELAY   = 2'd0,
    REG_MOVE_HOLD      = 2'd1,
    REG_STEPS_PER_MOVE = 2'd2
  } cfg_reg_t;

  localparam logic [MsW-1:0]   RUNOUT_DELAY_RST   = 16'd32;
  localparam logic [MsW-1:0]   MOVE_HOLD_RST      = 16'd2000;
  localparam logic [StepW-1:0] STEPS_PER_MOVE_RST = 6'd32;

endpackage

// ----- sv/filament_load_assist_sequencer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// filament_load_assist_sequencer_unit
// Runout detection and retract/extend step sequencing, one tick per item.
// ----------------------------------------------------------------------------
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  in       | in_valid / in_ready | now_ms[31:0], filament_present
//  out      | out_valid/out_ready | step_pulse, phase_now[2:0], steps_done[5:0]
//  cfg      | cfg_write           | cfg_index[1:0], cfg_data[15:0]
//
//  One item per clock unless stalled; out_valid is set the cycle after accept.
//  The whole tick update (two 32-bit time differences and their compares,
//  then the step compare) sits between the state/input and the result register.
//  The single output register decouples the sides: in_ready is high whenever
//  that register is empty or being drained in the same cycle.
//  Synchronous reset restores the phase, arm, timers, step count and config.
// ----------------------------------------------------------------------------
module filament_load_assist_sequencer_unit (
  input  logic                          clk,
  input  logic                          rst,
  // tick input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [flas_pkg::TimeW-1:0]    now_ms,
  input  logic                          filament_present,
  // result output
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          step_pulse,
  output logic [flas_pkg::PhaseW-1:0]   phase_now,
  output logic [flas_pkg::StepW-1:0]    steps_done,
  // configuration writes
  input  logic                          cfg_write,
  input  logic [flas_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [flas_pkg::MsW-1:0]      cfg_data
);

  // configuration
  logic [flas_pkg::MsW-1:0]   runout_delay_ms;
  logic [flas_pkg::MsW-1:0]   move_hold_ms;
  logic [flas_pkg::StepW-1:0] steps_per_move;

  // sequencer state
  flas_pkg::phase_t            phase;
  logic                        runout_armed;
  logic [flas_pkg::TimeW-1:0]  runout_start;
  logic [flas_pkg::TimeW-1:0]  move_start;
  logic [flas_pkg::StepW-1:0]  step_count;

  // next-state values for an accepted tick
  flas_pkg::phase_t            phase_next;
  logic                        runout_armed_next;
  logic [flas_pkg::TimeW-1:0]  runout_start_next;
  logic [flas_pkg::TimeW-1:0]  move_start_next;
  logic [flas_pkg::StepW-1:0]  step_count_next;
  logic                        pulse_next;

  logic                        in_fire;
  logic                        runout_fire;
  logic                        ret_hold_done;
  logic                        ext_hold_done;
  logic                        start_move;
  logic [flas_pkg::TimeW-1:0]  runout_base;
  logic [flas_pkg::TimeW-1:0]  runout_elapsed;
  logic [flas_pkg::TimeW-1:0]  move_elapsed;
  flas_pkg::phase_t            phase_mid;
  logic [flas_pkg::StepW-1:0]  step_mid;
  logic [flas_pkg::StepW-1:0]  step_inc;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // --- tick update -----------------------------------------------------------
  // Order within a tick: waiting, retract hold, extend hold, then pulsing.
  // A transition into a pulsing phase pulses in the same tick if steps_per_move is nonzero.
  always_comb begin
    // newly armed tick measures from now, so elapsed is zero
    runout_base    = runout_armed ? runout_start : now_ms;
    runout_elapsed = now_ms - runout_base;
    move_elapsed   = now_ms - move_start;

    runout_fire   = (phase == flas_pkg::PH_WAIT) && !filament_present &&
                    (runout_elapsed >= {16'd0, runout_delay_ms});
    ret_hold_done = (phase == flas_pkg::PH_HOLD_RET) &&
                    (move_elapsed > {16'd0, move_hold_ms});
    ext_hold_done = (phase == flas_pkg::PH_HOLD_EXT) &&
                    (move_elapsed > {16'd0, move_hold_ms});
    start_move    = runout_fire || ret_hold_done;

    // arm bookkeeping; a fire always clears the arm
    runout_armed_next = runout_armed;
    runout_start_next = runout_start;
    if (phase == flas_pkg::PH_WAIT && !runout_armed && !filament_present) begin
      runout_armed_next = 1'b1;
      runout_start_next = now_ms;
    end
    if (runout_fire) begin
      runout_armed_next = 1'b0;
    end

    if (runout_fire) begin
      phase_mid = flas_pkg::PH_PULSE_RET;
    end else if (ret_hold_done) begin
      phase_mid = flas_pkg::PH_PULSE_EXT;
    end else if (ext_hold_done) begin
      phase_mid = flas_pkg::PH_WAIT;
    end else begin
      phase_mid = phase;
    end
    step_mid        = start_move ? '0 : step_count;
    move_start_next = start_move ? now_ms : move_start;

    // pulsing
    step_inc        = step_mid + 6'd1;
    pulse_next      = 1'b0;
    phase_next      = phase_mid;
    step_count_next = step_mid;
    if ((phase_mid == flas_pkg::PH_PULSE_RET || phase_mid == flas_pkg::PH_PULSE_EXT) &&
        (step_mid < steps_per_move)) begin
      pulse_next      = 1'b1;
      step_count_next = step_inc;
      if (step_inc >= steps_per_move) begin
        phase_next = (phase_mid == flas_pkg::PH_PULSE_EXT) ? flas_pkg::PH_HOLD_EXT
                                                           : flas_pkg::PH_HOLD_RET;
      end
    end
  end

  // --- configuration ---------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      runout_delay_ms <= flas_pkg::RUNOUT_DELAY_RST;
      move_hold_ms    <= flas_pkg::MOVE_HOLD_RST;
      steps_per_move  <= flas_pkg::STEPS_PER_MOVE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        flas_pkg::REG_RUNOUT_DELAY:   runout_delay_ms <= cfg_data;
        flas_pkg::REG_MOVE_HOLD:      move_hold_ms    <= cfg_data;
        flas_pkg::REG_STEPS_PER_MOVE: steps_per_move  <= cfg_data[flas_pkg::StepW-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // --- state and result register ---------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= flas_pkg::PH_WAIT;
      runout_armed <= 1'b0;
      runout_start <= '0;
      move_start   <= '0;
      step_count   <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (in_fire) begin
        phase        <= phase_next;
        runout_armed <= runout_armed_next;
        runout_start <= runout_start_next;
        move_start   <= move_start_next;
        step_count   <= step_count_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload; no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      step_pulse <= pulse_next;
      phase_now  <= phase_next;
      steps_done <= step_count_next;
    end
  end

  // --- checks ----------------------------------------------------------------
  // arm can only be set while waiting and is dropped on the fire that leaves it
  a_arm_only_waiting: assert property (@(posedge clk) disable iff (rst)
    (phase != flas_pkg::PH_WAIT) |-> !runout_armed)
    else $error("runout arm set outside waiting");

  // a hold is entered only after at least one step
  a_hold_has_steps: assert property (@(posedge clk) disable iff (rst)
    (phase == flas_pkg::PH_HOLD_RET || phase == flas_pkg::PH_HOLD_EXT) |->
      (step_count != '0))
    else $error("hold phase with zero steps");

  // a pulse always leaves a nonzero count and a non-waiting phase
  a_pulse_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && step_pulse) |->
      (steps_done != '0 && phase_now != flas_pkg::PH_WAIT))
    else $error("step pulse with inconsistent result");

  // stalled result register blocks input
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with empty result register");

  // an accepted tick always produces a result next cycle
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("accepted tick without result");

endmodule
